// ===== sv/nnis_pkg.sv =====
// shared constants, codes and transfer types for the nearest neighbour scaler
// no dependencies
package nnis_pkg;

   localparam int MAX_SRC_WIDTH  = 256;
   localparam int MAX_SRC_HEIGHT = 256;
   localparam int PIXEL_BITS     = 32;
   localparam int DST_MAX        = 4096;

   localparam int STORE_DEPTH = MAX_SRC_WIDTH * MAX_SRC_HEIGHT;
   localparam int ADDR_W      = $clog2(STORE_DEPTH);
   localparam int SX_W        = $clog2(MAX_SRC_WIDTH);
   localparam int SY_W        = $clog2(MAX_SRC_HEIGHT);

   localparam int SIZE_W     = 9;
   localparam int DSIZE_W    = 13;
   localparam int POS_W      = 12;
   localparam int COLOR_W    = 32;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 13;

   localparam int NUM_W     = POS_W + SIZE_W;
   localparam int DIV_CNT_W = $clog2(NUM_W);

   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   localparam logic [CSR_IDX_W-1:0] CSR_SRC_WIDTH  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_SRC_HEIGHT = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_DST_WIDTH  = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_DST_HEIGHT = 2'd3;

   localparam logic CMD_LOAD = 1'b0;
   localparam logic CMD_EMIT = 1'b1;

   typedef enum logic [2:0] {
      ST_RUN,
      ST_CLAMP,
      ST_SETUP,
      ST_DIV,
      ST_DONE
   } state_type;

   typedef enum logic [1:0] {
      JOB_COL,
      JOB_XSTEP,
      JOB_ROW,
      JOB_YSTEP
   } job_type;

   typedef struct packed {
      logic               cmd;
      logic [COLOR_W-1:0] pixel_in;
   } req_type;

   typedef struct packed {
      logic [COLOR_W-1:0] pixel_out;
      logic [POS_W-1:0]   dst_x;
      logic [POS_W-1:0]   dst_y;
      logic               last_pixel;
   } rsp_type;

   typedef struct packed {
      logic                  emit;
      logic [ADDR_W-1:0]     load_addr;
      logic [SX_W-1:0]       sx;
      logic [SY_W-1:0]       sy;
      logic [PIXEL_BITS-1:0] pixel;
      logic [POS_W-1:0]      dst_x;
      logic [POS_W-1:0]      dst_y;
      logic                  last;
   } entry_type;

endpackage

// ===== sv/nnis_ram.sv =====
// generic single write port, single read port ram with registered read data
// read-first on a same-address collision; no dependencies
module nnis_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic                     re,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

// ===== sv/nnis_fifo.sv =====
// short queue of classified items between front and back
// depends on nnis_pkg
module nnis_fifo
   import nnis_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   input  logic      push,
   input  entry_type push_entry,
   output logic      full,
   input  logic      pop,
   output entry_type pop_entry,
   output logic      empty
);

   entry_type         slot_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0] count_ff, count_in;
   logic              do_push, do_pop;

   assign full    = (count_ff == QCNT_W'(QUEUE_DEPTH));
   assign empty   = (count_ff == '0);
   assign do_push = push & ~full;
   assign do_pop  = pop & ~empty;

   assign pop_entry = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = do_push ? QPTR_W'(wr_ptr_ff + QPTR_W'(1)) : wr_ptr_ff;
      rd_ptr_in = do_pop ? QPTR_W'(rd_ptr_ff + QPTR_W'(1)) : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push & ~do_pop) begin
         count_in = QCNT_W'(count_ff + QCNT_W'(1));
      end else if (do_pop & ~do_push) begin
         count_in = QCNT_W'(count_ff - QCNT_W'(1));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

// ===== sv/nnis_front.sv =====
// front end: size registers, position counters, source index accumulators
// and the shared divider that rebuilds them; depends on nnis_pkg
module nnis_front
   import nnis_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   output logic                  busy,
   input  req_type               req_data,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   input  logic                  queue_full,
   output logic                  queue_push,
   output entry_type             queue_entry,
   output logic [SIZE_W-1:0]     src_width
);

   state_type state_ff, state_in;
   job_type   job_ff, job_in;

   logic [DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic [NUM_W-1:0]     nq_ff, nq_in;
   logic [DSIZE_W-1:0]   rem_ff, rem_in;
   logic [DSIZE_W-1:0]   div_ff, div_in;

   logic [SIZE_W-1:0]  sw_ff, sw_in, sh_ff, sh_in;
   logic [DSIZE_W-1:0] dw_ff, dw_in, dh_ff, dh_in;

   logic [POS_W-1:0]  col_ff, col_in, row_ff, row_in;
   logic [ADDR_W-1:0] lp_ff, lp_in, total_m1_ff, total_m1_in;

   logic [SX_W-1:0]  qx_ff, qx_in;
   logic [SX_W:0]    ax_ff, ax_in;
   logic [POS_W-1:0] rx_ff, rx_in, bx_ff, bx_in;
   logic [SY_W-1:0]  qy_ff, qy_in;
   logic [SY_W:0]    ay_ff, ay_in;
   logic [POS_W-1:0] ry_ff, ry_in, by_ff, by_in;

   logic                accept;
   logic                col_last, row_last;
   logic [DSIZE_W-1:0]  rsum_x, rsum_y;
   logic                carry_x, carry_y;
   logic [POS_W-1:0]    rx_next, ry_next;
   logic [SX_W:0]       qsum_x;
   logic [SY_W:0]       qsum_y;
   logic [DSIZE_W:0]    rem_t, rem_sub;
   logic                rem_ge;
   logic [2*SIZE_W-1:0] total;

   function automatic logic [SIZE_W-1:0] clamp_src(input logic [SIZE_W-1:0] v,
                                                   input logic [SIZE_W-1:0] hi);
      logic [SIZE_W-1:0] r;
      r = v;
      if (v == '0) begin
         r = SIZE_W'(1);
      end else if (v > hi) begin
         r = hi;
      end
      return r;
   endfunction

   function automatic logic [DSIZE_W-1:0] clamp_dst(input logic [DSIZE_W-1:0] v);
      logic [DSIZE_W-1:0] r;
      r = v;
      if (v == '0) begin
         r = DSIZE_W'(1);
      end else if (v > DSIZE_W'(DST_MAX)) begin
         r = DSIZE_W'(DST_MAX);
      end
      return r;
   endfunction

   assign busy      = (state_ff != ST_RUN) | queue_full;
   assign accept    = start & ~busy;
   assign src_width = sw_ff;

   assign col_last = ({1'b0, col_ff} == DSIZE_W'(dw_ff - DSIZE_W'(1)));
   assign row_last = ({1'b0, row_ff} == DSIZE_W'(dh_ff - DSIZE_W'(1)));

   // index accumulators: add the per-step quotient and remainder, fold once
   assign rsum_x  = DSIZE_W'({1'b0, rx_ff} + {1'b0, bx_ff});
   assign carry_x = (rsum_x >= dw_ff);
   assign rx_next = carry_x ? POS_W'(rsum_x - dw_ff) : POS_W'(rsum_x);
   assign qsum_x  = (SX_W + 1)'({1'b0, qx_ff} + ax_ff + (SX_W + 1)'(carry_x));

   assign rsum_y  = DSIZE_W'({1'b0, ry_ff} + {1'b0, by_ff});
   assign carry_y = (rsum_y >= dh_ff);
   assign ry_next = carry_y ? POS_W'(rsum_y - dh_ff) : POS_W'(rsum_y);
   assign qsum_y  = (SY_W + 1)'({1'b0, qy_ff} + ay_ff + (SY_W + 1)'(carry_y));

   // restoring divider step
   assign rem_t   = {rem_ff, nq_ff[NUM_W-1]};
   assign rem_ge  = (rem_t >= {1'b0, div_ff});
   assign rem_sub = DSIZE_W'(rem_t - {1'b0, div_ff}) == '0 ? '0 :
                    (DSIZE_W + 1)'(rem_t - {1'b0, div_ff});

   assign total = (2 * SIZE_W)'(sw_ff) * (2 * SIZE_W)'(sh_ff);

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_RUN:   state_in = ST_RUN;
         ST_CLAMP: state_in = ST_SETUP;
         ST_SETUP: state_in = ST_DIV;
         ST_DIV: begin
            if (cnt_ff == DIV_CNT_W'(NUM_W - 1)) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE:  state_in = (job_ff == JOB_YSTEP) ? ST_RUN : ST_SETUP;
         default:  state_in = ST_CLAMP;
      endcase
      if (csr_we) begin
         state_in = ST_CLAMP;
      end
   end

   always_comb begin
      job_in      = job_ff;
      cnt_in      = cnt_ff;
      nq_in       = nq_ff;
      rem_in      = rem_ff;
      div_in      = div_ff;
      sw_in       = sw_ff;
      sh_in       = sh_ff;
      dw_in       = dw_ff;
      dh_in       = dh_ff;
      col_in      = col_ff;
      row_in      = row_ff;
      lp_in       = lp_ff;
      total_m1_in = total_m1_ff;
      qx_in       = qx_ff;
      ax_in       = ax_ff;
      rx_in       = rx_ff;
      bx_in       = bx_ff;
      qy_in       = qy_ff;
      ay_in       = ay_ff;
      ry_in       = ry_ff;
      by_in       = by_ff;

      queue_push            = 1'b0;
      queue_entry.emit      = (req_data.cmd == CMD_EMIT);
      queue_entry.load_addr = lp_ff;
      queue_entry.sx        = qx_ff;
      queue_entry.sy        = qy_ff;
      queue_entry.pixel     = PIXEL_BITS'(req_data.pixel_in);
      queue_entry.dst_x     = col_ff;
      queue_entry.dst_y     = row_ff;
      queue_entry.last      = col_last & row_last;

      if (csr_we) begin
         case (csr_index)
            CSR_SRC_WIDTH:
               sw_in = clamp_src(csr_wdata[SIZE_W-1:0], SIZE_W'(MAX_SRC_WIDTH));
            CSR_SRC_HEIGHT:
               sh_in = clamp_src(csr_wdata[SIZE_W-1:0], SIZE_W'(MAX_SRC_HEIGHT));
            CSR_DST_WIDTH:  dw_in = clamp_dst(csr_wdata);
            CSR_DST_HEIGHT: dh_in = clamp_dst(csr_wdata);
            default: ;
         endcase
      end

      case (state_ff)
         ST_RUN: begin
            if (accept) begin
               queue_push = 1'b1;
               if (req_data.cmd == CMD_LOAD) begin
                  lp_in = (lp_ff == total_m1_ff) ? '0 : ADDR_W'(lp_ff + ADDR_W'(1));
               end else if (col_last) begin
                  col_in = '0;
                  qx_in  = '0;
                  rx_in  = '0;
                  if (row_last) begin
                     row_in = '0;
                     qy_in  = '0;
                     ry_in  = '0;
                  end else begin
                     row_in = POS_W'(row_ff + POS_W'(1));
                     qy_in  = qsum_y[SY_W-1:0];
                     ry_in  = ry_next;
                  end
               end else begin
                  col_in = POS_W'(col_ff + POS_W'(1));
                  qx_in  = qsum_x[SX_W-1:0];
                  rx_in  = rx_next;
               end
            end
         end
         ST_CLAMP: begin
            job_in      = JOB_COL;
            total_m1_in = ADDR_W'(total - (2 * SIZE_W)'(1));
            if ({1'b0, col_ff} >= dw_ff) begin
               col_in = '0;
            end
            if ({1'b0, row_ff} >= dh_ff) begin
               row_in = '0;
            end
         end
         ST_SETUP: begin
            if (lp_ff > total_m1_ff) begin
               lp_in = '0;
            end
            cnt_in = '0;
            rem_in = '0;
            case (job_ff)
               JOB_COL: begin
                  nq_in  = NUM_W'(col_ff) * NUM_W'(sw_ff);
                  div_in = dw_ff;
               end
               JOB_XSTEP: begin
                  nq_in  = NUM_W'(sw_ff);
                  div_in = dw_ff;
               end
               JOB_ROW: begin
                  nq_in  = NUM_W'(row_ff) * NUM_W'(sh_ff);
                  div_in = dh_ff;
               end
               JOB_YSTEP: begin
                  nq_in  = NUM_W'(sh_ff);
                  div_in = dh_ff;
               end
               default: ;
            endcase
         end
         ST_DIV: begin
            cnt_in = DIV_CNT_W'(cnt_ff + DIV_CNT_W'(1));
            nq_in  = {nq_ff[NUM_W-2:0], rem_ge};
            rem_in = rem_ge ? rem_sub[DSIZE_W-1:0] : rem_t[DSIZE_W-1:0];
         end
         ST_DONE: begin
            case (job_ff)
               JOB_COL: begin
                  qx_in  = nq_ff[SX_W-1:0];
                  rx_in  = rem_ff[POS_W-1:0];
                  job_in = JOB_XSTEP;
               end
               JOB_XSTEP: begin
                  ax_in  = nq_ff[SX_W:0];
                  bx_in  = rem_ff[POS_W-1:0];
                  job_in = JOB_ROW;
               end
               JOB_ROW: begin
                  qy_in  = nq_ff[SY_W-1:0];
                  ry_in  = rem_ff[POS_W-1:0];
                  job_in = JOB_YSTEP;
               end
               JOB_YSTEP: begin
                  ay_in  = nq_ff[SY_W:0];
                  by_in  = rem_ff[POS_W-1:0];
                  job_in = JOB_COL;
               end
               default: ;
            endcase
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLAMP;
         job_ff   <= JOB_COL;
         sw_ff    <= SIZE_W'(256);
         sh_ff    <= SIZE_W'(256);
         dw_ff    <= DSIZE_W'(256);
         dh_ff    <= DSIZE_W'(256);
         col_ff   <= '0;
         row_ff   <= '0;
         lp_ff    <= '0;
      end else begin
         state_ff <= state_in;
         job_ff   <= job_in;
         sw_ff    <= sw_in;
         sh_ff    <= sh_in;
         dw_ff    <= dw_in;
         dh_ff    <= dh_in;
         col_ff   <= col_in;
         row_ff   <= row_in;
         lp_ff    <= lp_in;
      end
   end

   always_ff @(posedge clock) begin
      cnt_ff      <= cnt_in;
      nq_ff       <= nq_in;
      rem_ff      <= rem_in;
      div_ff      <= div_in;
      total_m1_ff <= total_m1_in;
      qx_ff       <= qx_in;
      ax_ff       <= ax_in;
      rx_ff       <= rx_in;
      bx_ff       <= bx_in;
      qy_ff       <= qy_in;
      ay_ff       <= ay_in;
      ry_ff       <= ry_in;
      by_ff       <= by_in;
   end

`ifndef SYNTHESIS
   a_pos_in_range: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_RUN |-> ({1'b0, col_ff} < dw_ff) && ({1'b0, row_ff} < dh_ff))
      else $error("destination position outside the destination image");

   a_rem_in_range: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_RUN |-> ({1'b0, rx_ff} < dw_ff) && ({1'b0, ry_ff} < dh_ff))
      else $error("index accumulator remainder not folded");

   a_src_in_range: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_RUN |->
         (SIZE_W'(qx_ff) < sw_ff) && (SIZE_W'(qy_ff) < sh_ff) && (lp_ff <= total_m1_ff))
      else $error("source index outside the source image");
`endif

endmodule

// ===== sv/nnis_back.sv =====
// back end: writes loaded pixels to the image store and reads scaled pixels
// out through the index stage; depends on nnis_pkg and nnis_ram
module nnis_back
   import nnis_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              queue_empty,
   output logic              queue_pop,
   input  entry_type         queue_entry,
   input  logic [SIZE_W-1:0] src_width,
   output logic              rsp_strobe,
   output rsp_type           rsp_data
);

   typedef struct packed {
      logic [POS_W-1:0] dst_x;
      logic [POS_W-1:0] dst_y;
      logic             last;
   } tag_type;

   logic                  ram_we;
   logic [PIXEL_BITS-1:0] ram_rdata;

   logic              rd_valid_ff, rd_valid_in;
   logic [ADDR_W-1:0] rd_addr_ff, rd_addr_in;
   tag_type           rd_tag_ff, rd_tag_in;
   logic              data_valid_ff;
   tag_type           data_tag_ff;
   logic              rsp_valid_ff;
   rsp_type           rsp_ff, rsp_in;

   assign queue_pop = ~queue_empty;
   assign ram_we    = queue_pop & ~queue_entry.emit;

   always_comb begin
      rd_valid_in     = queue_pop & queue_entry.emit;
      rd_addr_in      = ADDR_W'(ADDR_W'(queue_entry.sy) * ADDR_W'(src_width)
                                + ADDR_W'(queue_entry.sx));
      rd_tag_in.dst_x = queue_entry.dst_x;
      rd_tag_in.dst_y = queue_entry.dst_y;
      rd_tag_in.last  = queue_entry.last;

      rsp_in.pixel_out  = COLOR_W'(ram_rdata);
      rsp_in.dst_x      = data_tag_ff.dst_x;
      rsp_in.dst_y      = data_tag_ff.dst_y;
      rsp_in.last_pixel = data_tag_ff.last;
   end

   nnis_ram #(
      .WIDTH (PIXEL_BITS),
      .DEPTH (STORE_DEPTH)
   ) u_store (
      .clock (clock),
      .we    (ram_we),
      .waddr (queue_entry.load_addr),
      .wdata (queue_entry.pixel),
      .re    (rd_valid_ff),
      .raddr (rd_addr_ff),
      .rdata (ram_rdata)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_valid_ff   <= 1'b0;
         data_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         rd_valid_ff   <= rd_valid_in;
         data_valid_ff <= rd_valid_ff;
         rsp_valid_ff  <= data_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      rd_addr_ff  <= rd_addr_in;
      rd_tag_ff   <= rd_tag_in;
      data_tag_ff <= rd_tag_ff;
      if (data_valid_ff) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_strobe = rsp_valid_ff;
   assign rsp_data   = rsp_ff;

`ifndef SYNTHESIS
   a_emit_gives_result: assert property (@(posedge clock) disable iff (reset)
      queue_pop && queue_entry.emit |=> ##2 rsp_strobe)
      else $error("emit transfer lost in the read pipeline");

   a_load_gives_none: assert property (@(posedge clock) disable iff (reset)
      queue_pop && !queue_entry.emit |=> ##2 !rsp_strobe)
      else $error("load transfer produced a result");
`endif

endmodule

// ===== sv/nearest_neighbor_image_scaler.sv =====
// Nearest neighbour image scaler. A transfer is taken when start is high and busy is low.
// A load (cmd 0) writes the next source pixel into the 64k-entry image store and gives no
// result; an emit (cmd 1) gives the next destination pixel in raster order, on rsp_data for
// one cycle with rsp_strobe, by way of the queue, the read address register, the store read
// register and the result register. The receiver cannot stall, so in normal running the block
// takes one transfer every cycle: the source column and row are tracked by add-and-fold
// accumulators, and the only limit is the single store write/read port pair. After reset and
// after every csr write, busy stays high while one shared 21-step restoring divider rebuilds
// the accumulators from the new sizes and the current position; csr writes are taken at any time.
// depends on nnis_pkg, nnis_front, nnis_fifo, nnis_back
module nearest_neighbor_image_scaler
   import nnis_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   output logic                  busy,
   input  req_type               req_data,
   output logic                  rsp_strobe,
   output rsp_type               rsp_data,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   logic              queue_push, queue_full, queue_pop, queue_empty;
   entry_type         push_entry, pop_entry;
   logic [SIZE_W-1:0] src_width;

   nnis_front u_front (
      .clock       (clock),
      .reset       (reset),
      .start       (start),
      .busy        (busy),
      .req_data    (req_data),
      .csr_we      (csr_we),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata),
      .queue_full  (queue_full),
      .queue_push  (queue_push),
      .queue_entry (push_entry),
      .src_width   (src_width)
   );

   nnis_fifo u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (queue_push),
      .push_entry (push_entry),
      .full       (queue_full),
      .pop        (queue_pop),
      .pop_entry  (pop_entry),
      .empty      (queue_empty)
   );

   nnis_back u_back (
      .clock       (clock),
      .reset       (reset),
      .queue_empty (queue_empty),
      .queue_pop   (queue_pop),
      .queue_entry (pop_entry),
      .src_width   (src_width),
      .rsp_strobe  (rsp_strobe),
      .rsp_data    (rsp_data)
   );

endmodule

// ===== sim/nnis_checker.sv =====
// transfer monitor and scoreboard for the nearest neighbour scaler: tracks sizes, source
// image and output position, predicts each emitted pixel and compares it with rsp_data
// depends on nnis_pkg
`timescale 1ns / 100ps
module nnis_checker
   import nnis_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  logic                  busy,
   input  req_type               req_data,
   input  logic                  rsp_strobe,
   input  rsp_type               rsp_data,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   output int                    fail_count,
   output int                    pending
);

   logic [COLOR_W-1:0] pix_mem [STORE_DEPTH];
   int unsigned        wr_ptr;
   int unsigned        col_ptr;
   int unsigned        row_ptr;
   logic [SIZE_W-1:0]  reg_sw;
   logic [SIZE_W-1:0]  reg_sh;
   logic [DSIZE_W-1:0] reg_dw;
   logic [DSIZE_W-1:0] reg_dh;
   rsp_type            awaited_pixels [$];
   int                 fails = 0;

   function automatic int unsigned bound_size(int unsigned v, int unsigned hi);
      if (v == 0) return 1;
      if (v > hi) return hi;
      return v;
   endfunction

   task automatic track_transfer(req_type r);
      int unsigned sw;
      int unsigned sh;
      int unsigned dw;
      int unsigned dh;
      int unsigned total;
      int unsigned sx;
      int unsigned sy;
      rsp_type     px;
      sw = bound_size(32'(reg_sw), MAX_SRC_WIDTH);
      sh = bound_size(32'(reg_sh), MAX_SRC_HEIGHT);
      dw = bound_size(32'(reg_dw), DST_MAX);
      dh = bound_size(32'(reg_dh), DST_MAX);
      total = sw * sh;
      if (r.cmd == CMD_LOAD) begin
         if (wr_ptr >= total) wr_ptr = 0;
         pix_mem[ADDR_W'(wr_ptr)] = r.pixel_in;
         wr_ptr++;
         if (wr_ptr >= total) wr_ptr = 0;
      end else begin
         if (col_ptr >= dw) col_ptr = 0;
         if (row_ptr >= dh) row_ptr = 0;
         sx = col_ptr * sw / dw;
         sy = row_ptr * sh / dh;
         px.pixel_out  = pix_mem[ADDR_W'(sy * sw + sx)];
         px.dst_x      = POS_W'(col_ptr);
         px.dst_y      = POS_W'(row_ptr);
         px.last_pixel = (col_ptr == dw - 1) && (row_ptr == dh - 1);
         awaited_pixels.push_back(px);
         col_ptr++;
         if (col_ptr >= dw) begin
            col_ptr = 0;
            row_ptr++;
            if (row_ptr >= dh) row_ptr = 0;
         end
      end
   endtask

   task automatic check_pixel(rsp_type got);
      rsp_type want;
      if (awaited_pixels.size() == 0) begin
         fails++;
         if (fails <= 10)
            $display("unexpected pixel: colour %h x %0d y %0d last %b",
                     got.pixel_out, got.dst_x, got.dst_y, got.last_pixel);
      end else begin
         want = awaited_pixels.pop_front();
         if (got.pixel_out !== want.pixel_out || got.dst_x !== want.dst_x ||
             got.dst_y !== want.dst_y || got.last_pixel !== want.last_pixel) begin
            fails++;
            if (fails <= 10)
               $display("mismatch: expected %h x %0d y %0d last %b, got %h x %0d y %0d last %b",
                        want.pixel_out, want.dst_x, want.dst_y, want.last_pixel,
                        got.pixel_out, got.dst_x, got.dst_y, got.last_pixel);
         end
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         wr_ptr  = 0;
         col_ptr = 0;
         row_ptr = 0;
         reg_sw  = 9'd256;
         reg_sh  = 9'd256;
         reg_dw  = 13'd256;
         reg_dh  = 13'd256;
         awaited_pixels.delete();
      end else begin
         if (rsp_strobe) check_pixel(rsp_data);
         if (csr_we) begin
            case (csr_index)
               CSR_SRC_WIDTH:  reg_sw = csr_wdata[SIZE_W-1:0];
               CSR_SRC_HEIGHT: reg_sh = csr_wdata[SIZE_W-1:0];
               CSR_DST_WIDTH:  reg_dw = csr_wdata[DSIZE_W-1:0];
               CSR_DST_HEIGHT: reg_dh = csr_wdata[DSIZE_W-1:0];
               default: ;
            endcase
         end
         if (start && !busy) track_transfer(req_data);
      end
      fail_count <= fails;
      pending    <= awaited_pixels.size();
   end

endmodule

// ===== sim/tb_top.sv =====
// top level of the scaler testbench: clock, reset, size programming and load/emit stimulus
// depends on nnis_pkg, nearest_neighbor_image_scaler and nnis_checker
`timescale 1ns / 100ps
module tb_top;
   import nnis_pkg::*;

   localparam int CYCLE_LIMIT  = 400000;
   localparam int FLUSH_CYCLES = 8;
   localparam int ITEM_TARGET  = 1050;

   logic                  clock      = 1'b0;
   logic                  reset      = 1'b1;
   logic                  start      = 1'b0;
   logic                  busy;
   req_type               req_data   = '0;
   logic                  rsp_strobe;
   rsp_type               rsp_data;
   logic                  csr_we     = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index  = '0;
   logic [CSR_DATA_W-1:0] csr_wdata  = '0;
   int                    fail_count;
   int                    pending;
   int                    cycles     = 0;
   int                    items      = 0;

   always #5 clock = ~clock;

   nearest_neighbor_image_scaler dut (.*);

   nnis_checker u_checker (.*);

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles == CYCLE_LIMIT) begin
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   function automatic int unsigned usable(int unsigned v, int unsigned hi);
      if (v == 0) return 1;
      if (v > hi) return hi;
      return v;
   endfunction

   function automatic logic [CSR_DATA_W-1:0] pick_src_raw(bit tiny);
      logic [SIZE_W-1:0] v;
      if (tiny) v = SIZE_W'($urandom_range(0, 1));
      else begin
         case ($urandom_range(0, 39))
            0, 1:    v = '0;
            2:       v = 9'd256;
            3:       v = SIZE_W'($urandom_range(257, 511));
            default: v = SIZE_W'($urandom_range(1, 8));
         endcase
      end
      return {(CSR_DATA_W-SIZE_W)'($urandom), v};
   endfunction

   function automatic logic [CSR_DATA_W-1:0] pick_dst_raw();
      case ($urandom_range(0, 19))
         0:       return '0;
         1:       return CSR_DATA_W'(DST_MAX);
         2:       return CSR_DATA_W'($urandom_range(DST_MAX + 1, 8191));
         3:       return CSR_DATA_W'($urandom_range(17, DST_MAX - 1));
         default: return CSR_DATA_W'($urandom_range(1, 16));
      endcase
   endfunction

   task automatic send_word(logic op, logic [COLOR_W-1:0] colour);
      start    <= 1'b1;
      req_data <= '{cmd: op, pixel_in: colour};
      do @(posedge clock); while (busy);
      items++;
   endtask

   task automatic idle_gap(bit steady);
      int n;
      if (steady) return;
      case ($urandom_range(0, 19))
         0:             n = $urandom_range(12, 40);
         1, 2, 3, 4, 5: n = $urandom_range(1, 3);
         default:       n = 0;
      endcase
      if (n > 0) begin
         start <= 1'b0;
         repeat (n) @(posedge clock);
      end
   endtask

   // hold off until every emitted pixel has come back
   task automatic drain();
      start <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
   endtask

   task automatic write_csr(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] val);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
   endtask

   task automatic program_sizes(logic [CSR_DATA_W-1:0] sw, logic [CSR_DATA_W-1:0] sh,
                                logic [CSR_DATA_W-1:0] dw, logic [CSR_DATA_W-1:0] dh);
      drain();
      repeat (FLUSH_CYCLES) @(posedge clock);
      write_csr(CSR_SRC_WIDTH, sw);
      write_csr(CSR_SRC_HEIGHT, sh);
      write_csr(CSR_DST_WIDTH, dw);
      write_csr(CSR_DST_HEIGHT, dh);
      csr_we <= 1'b0;
   endtask

   // full source image first so that no emit reads an unwritten entry, then mixed traffic
   task automatic run_phase(logic [CSR_DATA_W-1:0] sw, logic [CSR_DATA_W-1:0] sh,
                            logic [CSR_DATA_W-1:0] dw, logic [CSR_DATA_W-1:0] dh);
      int unsigned total;
      int unsigned area;
      int unsigned n_mix;
      bit          steady;
      program_sizes(sw, sh, dw, dh);
      total  = usable(32'(sw[SIZE_W-1:0]), MAX_SRC_WIDTH) *
               usable(32'(sh[SIZE_W-1:0]), MAX_SRC_HEIGHT);
      area   = usable(32'(dw), DST_MAX) * usable(32'(dh), DST_MAX);
      steady = ($urandom_range(0, 3) == 0);
      repeat (total) begin
         send_word(CMD_LOAD, $urandom);
         idle_gap(steady);
      end
      n_mix = $urandom_range(4, 40);
      if (area * 2 < n_mix) n_mix = area * 2 + 1;
      repeat (n_mix) begin
         if ($urandom_range(0, 4) == 0) send_word(CMD_LOAD, $urandom);
         else send_word(CMD_EMIT, $urandom);
         if ($urandom_range(0, 63) == 0) drain();
         else idle_gap(steady);
      end
   endtask

   initial begin
      logic [CSR_DATA_W-1:0] sw;
      logic [CSR_DATA_W-1:0] sh;
      logic [CSR_DATA_W-1:0] dw;
      logic [CSR_DATA_W-1:0] dh;
      int                    phase;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // 2x2 source onto 4x3, extreme colours, full frame then two more to stop mid-row
      program_sizes(13'h1E02, 13'd2, 13'd4, 13'd3);
      send_word(CMD_LOAD, 32'h0000_0000);
      send_word(CMD_LOAD, 32'hFFFF_FFFF);
      send_word(CMD_LOAD, 32'hA5A5_5A5A);
      send_word(CMD_LOAD, 32'h5A5A_A5A5);
      repeat (14) send_word(CMD_EMIT, 32'hFFFF_FFFF);

      // zero sizes count as one, oversize destination height as the maximum
      program_sizes(13'd0, 13'h1E00, 13'd0, 13'h1FFF);
      send_word(CMD_LOAD, $urandom);
      repeat (3) send_word(CMD_EMIT, 32'h0000_0000);

      phase = 0;
      while (items < ITEM_TARGET) begin
         dw = pick_dst_raw();
         dh = pick_dst_raw();
         case (phase)
            0: begin
               sw = 13'd256;
               sh = pick_src_raw(1'b1);
               dw = CSR_DATA_W'(DST_MAX);
            end
            1: begin
               sw = pick_src_raw(1'b1);
               sh = 13'd256;
               dh = CSR_DATA_W'(DST_MAX);
            end
            default: begin
               sw = pick_src_raw(1'b0);
               sh = pick_src_raw(usable(32'(sw[SIZE_W-1:0]), MAX_SRC_WIDTH) > 8);
               if (usable(32'(sh[SIZE_W-1:0]), MAX_SRC_HEIGHT) > 8) sw = pick_src_raw(1'b1);
            end
         endcase
         run_phase(sw, sh, dw, dh);
         phase++;
      end

      drain();
      repeat (FLUSH_CYCLES) @(posedge clock);
      if (fail_count == 0) $display("SCOREBOARD CLEAN");
      else $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule

// ===== filelist.f =====
sv/nnis_pkg.sv
sv/nnis_ram.sv
sv/nnis_fifo.sv
sv/nnis_front.sv
sv/nnis_back.sv
sv/nearest_neighbor_image_scaler.sv
sim/nnis_checker.sv
sim/tb_top.sv
